[sv/lti_pkg.sv]
// shared types and constants for the tetrahedral 3d lut interpolator
// no dependencies; used by lti_front, lti_queue, lti_back and the top level
`default_nettype none

package lti_pkg;

	// index and term fields are sized for a table edge of up to 128
	localparam int LTI_IDX_W   = 7;
	localparam int LTI_TERM_W  = 21;
	localparam int LTI_QDEPTH  = 8;
	localparam int LTI_QAW     = 3;
	localparam int LTI_QCW     = 4;
	localparam int LTI_FRONT_STAGES = 4;

	localparam logic LTI_OP_LOAD  = 1'b0;
	localparam logic LTI_OP_PIXEL = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [12:0] entry_index;
		logic [15:0] entry_red;
		logic [15:0] entry_green;
		logic [15:0] entry_blue;
		logic [15:0] pixel_red;
		logic [15:0] pixel_green;
		logic [15:0] pixel_blue;
	} lti_in_t;

	typedef struct packed {
		logic [15:0] out_red;
		logic [15:0] out_green;
		logic [15:0] out_blue;
	} lti_out_t;

	// one classified item between front and back
	typedef struct packed {
		logic                  wr;
		logic [12:0]           waddr;
		logic [47:0]           wdata;
		logic [LTI_IDX_W-1:0]  rl;
		logic [LTI_IDX_W-1:0]  rh;
		logic [LTI_TERM_W-1:0] gtl;
		logic [LTI_TERM_W-1:0] gth;
		logic [LTI_TERM_W-1:0] btl;
		logic [LTI_TERM_W-1:0] bth;
		logic [2:0]            sel1;
		logic [2:0]            sel2;
		logic [16:0]           w0;
		logic [15:0]           w1;
		logic [15:0]           w2;
		logic [15:0]           w3;
	} lti_job_t;

endpackage

`default_nettype wire

[sv/lti_front.sv]
// front end: scales pixels, splits corner index and fraction, picks the tetrahedron
// depends on lti_pkg
`default_nettype none

module lti_front #(
	parameter int MAX_EDGE = 17
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     take,
	input  wire lti_pkg::lti_in_t         item,
	input  wire logic [$clog2(MAX_EDGE+1)-1:0]   eff,
	input  wire logic [2*$clog2(MAX_EDGE+1)-1:0] e2,
	output lti_pkg::lti_job_t             job,
	output logic                          job_valid
);
	import lti_pkg::*;

	localparam int EW = $clog2(MAX_EDGE + 1);
	localparam int TW = 16 + EW;

	function automatic logic [2*EW+15:0] split(input logic [TW-1:0] t);
		logic [16:0]   s;
		logic [EW-1:0] q;
		logic [15:0]   r;
		// 65536 is 1 mod 65535, so high part plus low part gives the remainder
		s = {1'b0, t[15:0]} + 17'(t[TW-1:16]);
		if (s >= 17'd65535) begin
			r = 16'(s - 17'd65535);
			q = t[TW-1:16] + 1'b1;
		end else begin
			r = s[15:0];
			q = t[TW-1:16];
		end
		return {q + EW'(r != 16'd0), q, r};
	endfunction

	lti_in_t       item_s1;
	logic          v_s1, v_s2, v_s3;
	logic          op_s2, op_s3;
	logic [12:0]   waddr_s2, waddr_s3;
	logic [47:0]   wdata_s2, wdata_s3;
	logic [TW-1:0] tr_s2, tg_s2, tb_s2;
	logic [EW-1:0] rl_s3, rh_s3, gl_s3, gh_s3, bl_s3, bh_s3;
	logic [15:0]   fx_s3, fy_s3, fz_s3;
	logic [EW-1:0] em1;
	logic [2*EW+15:0] sr, sg, sb;
	logic [2:0]    sel1, sel2;
	logic [15:0]   fmax, w1, w2, w3;
	logic [2*EW-1:0] gtl, gth;
	logic [3*EW-1:0] btl, bth;

	assign em1 = eff - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			job_valid <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			job_valid <= v_s3;
		end
	end

	assign sr = split(tr_s2);
	assign sg = split(tg_s2);
	assign sb = split(tb_s2);

	// tetrahedron choice, strict compares so ties fall to the later branch
	always_comb begin
		if (fx_s3 > fy_s3) begin
			if (fy_s3 > fz_s3) begin
				sel1 = 3'b100; sel2 = 3'b110; fmax = fx_s3;
				w1 = fx_s3 - fy_s3; w2 = fy_s3 - fz_s3; w3 = fz_s3;
			end else if (fx_s3 > fz_s3) begin
				sel1 = 3'b100; sel2 = 3'b101; fmax = fx_s3;
				w1 = fx_s3 - fz_s3; w2 = fz_s3 - fy_s3; w3 = fy_s3;
			end else begin
				sel1 = 3'b001; sel2 = 3'b101; fmax = fz_s3;
				w1 = fz_s3 - fx_s3; w2 = fx_s3 - fy_s3; w3 = fy_s3;
			end
		end else begin
			if (fz_s3 > fy_s3) begin
				sel1 = 3'b001; sel2 = 3'b011; fmax = fz_s3;
				w1 = fz_s3 - fy_s3; w2 = fy_s3 - fx_s3; w3 = fx_s3;
			end else if (fz_s3 > fx_s3) begin
				sel1 = 3'b010; sel2 = 3'b011; fmax = fy_s3;
				w1 = fy_s3 - fz_s3; w2 = fz_s3 - fx_s3; w3 = fx_s3;
			end else begin
				sel1 = 3'b010; sel2 = 3'b110; fmax = fy_s3;
				w1 = fy_s3 - fx_s3; w2 = fx_s3 - fz_s3; w3 = fz_s3;
			end
		end
	end

	assign gtl = gl_s3 * eff;
	assign gth = gh_s3 * eff;
	assign btl = bl_s3 * e2;
	assign bth = bh_s3 * e2;

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
		op_s2    <= item_s1.opcode;
		waddr_s2 <= item_s1.entry_index;
		wdata_s2 <= {item_s1.entry_red, item_s1.entry_green, item_s1.entry_blue};
		tr_s2    <= TW'(item_s1.pixel_red) * TW'(em1);
		tg_s2    <= TW'(item_s1.pixel_green) * TW'(em1);
		tb_s2    <= TW'(item_s1.pixel_blue) * TW'(em1);

		op_s3    <= op_s2;
		waddr_s3 <= waddr_s2;
		wdata_s3 <= wdata_s2;
		{rh_s3, rl_s3, fx_s3} <= sr;
		{gh_s3, gl_s3, fy_s3} <= sg;
		{bh_s3, bl_s3, fz_s3} <= sb;

		job.wr    <= (op_s3 == LTI_OP_LOAD);
		job.waddr <= waddr_s3;
		job.wdata <= wdata_s3;
		job.rl    <= LTI_IDX_W'(rl_s3);
		job.rh    <= LTI_IDX_W'(rh_s3);
		job.gtl   <= LTI_TERM_W'(gtl);
		job.gth   <= LTI_TERM_W'(gth);
		job.btl   <= LTI_TERM_W'(btl);
		job.bth   <= LTI_TERM_W'(bth);
		job.sel1  <= sel1;
		job.sel2  <= sel2;
		job.w0    <= 17'h10000 - {1'b0, fmax};
		job.w1    <= w1;
		job.w2    <= w2;
		job.w3    <= w3;
	end

endmodule

`default_nettype wire

[sv/lti_queue.sv]
// short job queue between front and back
// depends on lti_pkg
`default_nettype none

module lti_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire lti_pkg::lti_job_t din,
	input  wire logic              pop,
	output lti_pkg::lti_job_t      dout,
	output logic                   nonempty,
	output logic [lti_pkg::LTI_QCW-1:0] count
);
	import lti_pkg::*;

	lti_job_t             slot_q [LTI_QDEPTH];
	logic [LTI_QAW-1:0]   wp_q, rp_q;
	logic [LTI_QCW-1:0]   count_q;

	assign nonempty = (count_q != '0);
	assign count    = count_q;
	assign dout     = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			count_q <= count_q + LTI_QCW'(push) - LTI_QCW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= din;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < LTI_QCW'(LTI_QDEPTH)))
		else $error("job queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("job queue underflow");

endmodule

`default_nettype wire

[sv/lti_back.sv]
// back end: corner addresses, four replicated table banks, weighted blend
// depends on lti_pkg
`default_nettype none

module lti_back #(
	parameter int MAX_EDGE = 17
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lti_pkg::lti_job_t job,
	input  wire logic              job_valid,
	output logic                   pop,
	output logic                   done,
	output lti_pkg::lti_out_t      result
);
	import lti_pkg::*;

	localparam int DEPTH = MAX_EDGE * MAX_EDGE * MAX_EDGE;
	localparam int AW    = $clog2(DEPTH);

	logic                  v_b1, v_b2, v_b3;
	logic                  wr_b1, wr_b2, wok_b1;
	logic [AW-1:0]         waddr_b1;
	logic [47:0]           wdata_b1;
	logic [AW-1:0]         addr_b1 [4];
	logic [16:0]           w0_b1, w0_b2;
	logic [15:0]           w1_b1, w2_b1, w3_b1, w1_b2, w2_b2, w3_b2;
	logic [47:0]           rd_b2 [4];
	logic [32:0]           prod_b3 [3][4];
	logic [LTI_TERM_W-1:0] a0, a1, a2, a3;
	logic [34:0]           acc [3];
	logic [18:0]           shr [3];
	logic [15:0]           sat [3];

	assign pop = job_valid;

	assign a0 = LTI_TERM_W'(job.rl) + job.gtl + job.btl;
	assign a3 = LTI_TERM_W'(job.rh) + job.gth + job.bth;
	assign a1 = LTI_TERM_W'(job.sel1[2] ? job.rh : job.rl)
		+ (job.sel1[1] ? job.gth : job.gtl) + (job.sel1[0] ? job.bth : job.btl);
	assign a2 = LTI_TERM_W'(job.sel2[2] ? job.rh : job.rl)
		+ (job.sel2[1] ? job.gth : job.gtl) + (job.sel2[0] ? job.bth : job.btl);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
			v_b3 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_b1 <= job_valid;
			v_b2 <= v_b1;
			v_b3 <= v_b2 && !wr_b2;
			done <= v_b3;
		end
	end

	always_ff @(posedge clk) begin
		wr_b1      <= job.wr;
		wok_b1     <= (32'(job.waddr) < DEPTH);
		waddr_b1   <= AW'(job.waddr);
		wdata_b1   <= job.wdata;
		addr_b1[0] <= AW'(a0);
		addr_b1[1] <= AW'(a1);
		addr_b1[2] <= AW'(a2);
		addr_b1[3] <= AW'(a3);
		w0_b1 <= job.w0;
		w1_b1 <= job.w1;
		w2_b1 <= job.w2;
		w3_b1 <= job.w3;

		wr_b2 <= wr_b1;
		w0_b2 <= w0_b1;
		w1_b2 <= w1_b1;
		w2_b2 <= w2_b1;
		w3_b2 <= w3_b1;
	end

	// every bank takes each load so the four corners are read in the same cycle
	for (genvar k = 0; k < 4; k++) begin : g_bank
		logic [47:0] mem [DEPTH];
		always_ff @(posedge clk) begin
			if (v_b1 && wr_b1 && wok_b1) mem[waddr_b1] <= wdata_b1;
			rd_b2[k] <= mem[addr_b1[k]];
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_chan
		always_ff @(posedge clk) begin
			prod_b3[c][0] <= w0_b2 * rd_b2[0][47-16*c -: 16];
			prod_b3[c][1] <= 33'(w1_b2 * rd_b2[1][47-16*c -: 16]);
			prod_b3[c][2] <= 33'(w2_b2 * rd_b2[2][47-16*c -: 16]);
			prod_b3[c][3] <= 33'(w3_b2 * rd_b2[3][47-16*c -: 16]);
		end
		always_comb begin
			acc[c] = 35'(prod_b3[c][0]) + 35'(prod_b3[c][1]) + 35'(prod_b3[c][2])
				+ 35'(prod_b3[c][3]) + 35'd32768;
			shr[c] = acc[c][34:16];
			sat[c] = (shr[c] > 19'd65535) ? 16'hFFFF : shr[c][15:0];
		end
	end

	always_ff @(posedge clk) begin
		result.out_red   <= sat[0];
		result.out_green <= sat[1];
		result.out_blue  <= sat[2];
	end

	a_strobe_follows_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		v_b3 |=> done)
		else $error("pixel lost before result");
	a_no_stray_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		!v_b3 |=> !done)
		else $error("result strobe without pixel");
	a_weights_sum_to_one: assert property (@(posedge clk) disable iff (!arst_n)
		(v_b1 && !wr_b1) |->
		(18'(w0_b1) + 18'(w1_b1) + 18'(w2_b1) + 18'(w3_b1) == 18'h10000))
		else $error("tetrahedral weights do not sum to one");

endmodule

`default_nettype wire

[sv/lut3d_tetrahedral_interp_top.sv]
// top level of the tetrahedral 3d lut interpolator: edge register, front, queue, back
// depends on lti_pkg, lti_front, lti_queue, lti_back
`default_nettype none

// One item is taken per clock while busy is low. A load item (opcode 0) writes one
// RGB entry, red index fastest; a pixel item (opcode 1) returns one interpolated RGB
// result on result, marked by done for one cycle. The result cannot be held off.
// Throughput is one item per clock, set by the four replicated table banks that read
// all four tetrahedron corners in the same cycle. Busy rises only if the job queue
// between front and back nears full. An entry must be written before a pixel reads
// it. Write edge_size with cfg_valid/cfg_data only while no item is in flight; the block
// does not enforce this. Values below 2 act as 2, above MAX_EDGE as MAX_EDGE.
module lut3d_tetrahedral_interp_top #(
	parameter int MAX_EDGE = 17
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire lti_pkg::lti_in_t item,
	output logic                  done,
	output lti_pkg::lti_out_t     result,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [4:0]       cfg_data
);
	import lti_pkg::*;

	localparam int EW      = $clog2(MAX_EDGE + 1);
	localparam int RST_EFF = (17 > MAX_EDGE) ? MAX_EDGE : 17;

	logic [EW-1:0]      eff_q;
	logic [2*EW-1:0]    e2_q;
	logic [EW-1:0]      eff_new;
	lti_job_t           f_job, q_job;
	logic               f_valid, q_nonempty, q_pop;
	logic [LTI_QCW-1:0] q_count;

	assign cfg_ready = 1'b1;
	assign eff_new = (cfg_data < 5'd2) ? EW'(2)
		: (32'(cfg_data) > MAX_EDGE) ? EW'(MAX_EDGE) : EW'(cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_q <= EW'(RST_EFF);
			e2_q  <= (2*EW)'(RST_EFF * RST_EFF);
		end else if (cfg_valid && cfg_ready) begin
			eff_q <= eff_new;
			e2_q  <= eff_new * eff_new;
		end
	end

	// room for everything already inside the front stages
	assign busy = (q_count >= LTI_QCW'(LTI_QDEPTH - LTI_FRONT_STAGES));

	lti_front #(.MAX_EDGE(MAX_EDGE)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (start && !busy),
		.item      (item),
		.eff       (eff_q),
		.e2        (e2_q),
		.job       (f_job),
		.job_valid (f_valid)
	);

	lti_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_valid),
		.din      (f_job),
		.pop      (q_pop),
		.dout     (q_job),
		.nonempty (q_nonempty),
		.count    (q_count)
	);

	lti_back #(.MAX_EDGE(MAX_EDGE)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (q_job),
		.job_valid (q_nonempty),
		.pop       (q_pop),
		.done      (done),
		.result    (result)
	);

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// self-checking testbench for lut3d_tetrahedral_interp_top
// depends on lti_pkg and the rtl of the block; no files, no arguments
`timescale 1ns / 1ps

module tb;
	import lti_pkg::*;

	localparam int MAXE = 17;
	localparam int DEPTH = MAXE * MAXE * MAXE;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	lti_in_t item = '0;
	logic done;
	lti_out_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [4:0] cfg_data = 5'd17;

	lut3d_tetrahedral_interp_top #(.MAX_EDGE(MAXE)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	logic [47:0] lut_mirror [DEPTH];
	logic [4:0] edge_reg = 5'd17;
	lti_out_t pending_colors[$];
	int errors = 0;
	int n_pixels = 0;
	int n_loads = 0;
	int idle_pct = 0;
	// largest pixel component whose corners stay inside the loaded sub-cube
	int pix_max = 65535;

	function automatic int eff_edge();
		int e;
		e = int'(edge_reg);
		if (e < 2) e = 2;
		if (e > MAXE) e = MAXE;
		return e;
	endfunction

	function automatic int span_limit(input int span);
		return 65535 * (span - 1) / (eff_edge() - 1);
	endfunction

	function automatic void axis_split(input logic [15:0] pix, input int e,
			output int lo, output int hi, output longint frac);
		longint t, r;
		t = longint'(pix) * (e - 1);
		r = t % 65535;
		lo = int'(t / 65535);
		hi = lo + (r != 0 ? 1 : 0);
		frac = (r << 16) / 65535;
	endfunction

	function automatic int corner(input int r, input int g, input int b, input int e);
		int a;
		a = r + e * (g + e * b);
		return a < DEPTH ? a : 0;
	endfunction

	function automatic lti_out_t interp_color(input lti_in_t it);
		int e, rl, rh, gl, gh, bl, bh;
		longint fx, fy, fz, acc;
		int c[4];
		longint w[4];
		logic [15:0] ch_out[3];
		lti_out_t o;
		e = eff_edge();
		axis_split(it.pixel_red, e, rl, rh, fx);
		axis_split(it.pixel_green, e, gl, gh, fy);
		axis_split(it.pixel_blue, e, bl, bh, fz);
		c[0] = corner(rl, gl, bl, e);
		c[3] = corner(rh, gh, bh, e);
		if (fx > fy) begin
			if (fy > fz) begin
				c[1] = corner(rh, gl, bl, e); c[2] = corner(rh, gh, bl, e);
				w = '{65536 - fx, fx - fy, fy - fz, fz};
			end else if (fx > fz) begin
				c[1] = corner(rh, gl, bl, e); c[2] = corner(rh, gl, bh, e);
				w = '{65536 - fx, fx - fz, fz - fy, fy};
			end else begin
				c[1] = corner(rl, gl, bh, e); c[2] = corner(rh, gl, bh, e);
				w = '{65536 - fz, fz - fx, fx - fy, fy};
			end
		end else begin
			if (fz > fy) begin
				c[1] = corner(rl, gl, bh, e); c[2] = corner(rl, gh, bh, e);
				w = '{65536 - fz, fz - fy, fy - fx, fx};
			end else if (fz > fx) begin
				c[1] = corner(rl, gh, bl, e); c[2] = corner(rl, gh, bh, e);
				w = '{65536 - fy, fy - fz, fz - fx, fx};
			end else begin
				c[1] = corner(rl, gh, bl, e); c[2] = corner(rh, gh, bl, e);
				w = '{65536 - fy, fy - fx, fx - fz, fz};
			end
		end
		for (int ch = 0; ch < 3; ch++) begin
			acc = 32768;
			for (int k = 0; k < 4; k++)
				acc += w[k] * longint'(lut_mirror[c[k]][47 - 16 * ch -: 16]);
			acc = acc >>> 16;
			if (acc > 65535) acc = 65535;
			ch_out[ch] = acc[15:0];
		end
		o.out_red = ch_out[0];
		o.out_green = ch_out[1];
		o.out_blue = ch_out[2];
		return o;
	endfunction

	// result checker; done is sampled at the edge that accepts it
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_colors.size() == 0) begin
				$display("%0t unexpected result, expected none, actual %h", $time, result);
				errors++;
			end else begin
				lti_out_t exp_c;
				exp_c = pending_colors.pop_front();
				if (result.out_red !== exp_c.out_red) begin
					$display("%0t out_red expected %h actual %h", $time, exp_c.out_red,
						result.out_red);
					errors++;
				end
				if (result.out_green !== exp_c.out_green) begin
					$display("%0t out_green expected %h actual %h", $time,
						exp_c.out_green, result.out_green);
					errors++;
				end
				if (result.out_blue !== exp_c.out_blue) begin
					$display("%0t out_blue expected %h actual %h", $time, exp_c.out_blue,
						result.out_blue);
					errors++;
				end
			end
		end
	end

	// one transaction; the model is updated at the accepting edge
	task automatic send_item(input lti_in_t it);
		while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (it.opcode == LTI_OP_LOAD) begin
			n_loads++;
			if (it.entry_index < DEPTH) begin
				lut_mirror[it.entry_index] = {it.entry_red, it.entry_green, it.entry_blue};
			end
		end else begin
			n_pixels++;
			pending_colors = {pending_colors, interp_color(it)};
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_colors.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_edge(input logic [4:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		edge_reg = v;
	endtask

	function automatic lti_in_t load_item(input int idx, input logic [47:0] rgb);
		lti_in_t it;
		it = '0;
		it.opcode = LTI_OP_LOAD;
		it.entry_index = idx[12:0];
		{it.entry_red, it.entry_green, it.entry_blue} = rgb;
		it.pixel_red = 16'($urandom);
		it.pixel_green = 16'($urandom);
		it.pixel_blue = 16'($urandom);
		return it;
	endfunction

	function automatic lti_in_t pixel_item(input logic [15:0] r, input logic [15:0] g,
			input logic [15:0] b);
		lti_in_t it;
		it = '0;
		it.opcode = LTI_OP_PIXEL;
		it.entry_index = 13'($urandom);
		it.entry_red = 16'($urandom);
		it.entry_green = 16'($urandom);
		it.entry_blue = 16'($urandom);
		it.pixel_red = r;
		it.pixel_green = g;
		it.pixel_blue = b;
		return it;
	endfunction

	// fill the sub-cube of span points per axis at the current edge
	task automatic fill_table(input bit extremes, input int span);
		int e, a;
		logic [47:0] v;
		e = eff_edge();
		for (int bi = 0; bi < span; bi++) begin
			for (int gi = 0; gi < span; gi++) begin
				for (int ri = 0; ri < span; ri++) begin
					a = ri + e * (gi + e * bi);
					if (extremes) v = a[0] ? '1 : '0;
					else v = 48'({$urandom, $urandom});
					send_item(load_item(a, v));
				end
			end
		end
		pix_max = span_limit(span);
	endtask

	task automatic test_directed();
		set_edge(5'd2);
		fill_table(1'b1, 2);
		send_item(pixel_item(16'h0000, 16'h0000, 16'h0000));
		send_item(pixel_item(16'hffff, 16'hffff, 16'hffff));
		send_item(pixel_item(16'h8000, 16'h8000, 16'h8000)); // all fractions tied
		send_item(pixel_item(16'h9000, 16'h4000, 16'h2000));
		send_item(pixel_item(16'h9000, 16'h2000, 16'h4000));
		send_item(pixel_item(16'h2000, 16'h4000, 16'h9000));
		send_item(pixel_item(16'h4000, 16'h2000, 16'h9000));
		send_item(pixel_item(16'h2000, 16'h9000, 16'h4000));
		send_item(pixel_item(16'h4000, 16'h9000, 16'h2000));
		send_item(pixel_item(16'h7000, 16'h7000, 16'h1000)); // red and green tied
		send_item(pixel_item(16'h1000, 16'h7000, 16'h7000));
		send_item(pixel_item(16'hffff, 16'h0000, 16'hffff));
		// addresses past the table are dropped
		send_item(load_item(DEPTH, '1));
		send_item(load_item(8191, '1));
		send_item(pixel_item(16'h5555, 16'haaaa, 16'h0001));
	endtask

	task automatic random_pixels(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9, 0) == 0) begin
				send_item(load_item($urandom_range(eff_edge() ** 3 - 1, 0),
					48'({$urandom, $urandom})));
			end else if ($urandom_range(9, 0) == 0) begin
				send_item(pixel_item($urandom_range(1, 0) ? 16'(pix_max) : 16'h0000,
					16'($urandom_range(pix_max, 0)),
					$urandom_range(1, 0) ? 16'(pix_max) : 16'h0000));
			end else begin
				send_item(pixel_item(16'($urandom_range(pix_max, 0)),
					16'($urandom_range(pix_max, 0)), 16'($urandom_range(pix_max, 0))));
			end
		end
	endtask

	task automatic test_edges_and_idling();
		// the low settings clamp to two, the high ones to the maximum
		set_edge(5'd0);
		send_item(pixel_item(16'($urandom), 16'($urandom), 16'($urandom)));
		set_edge(5'd31);
		fill_table(1'b0, 4);
		idle_pct = 34;
		random_pixels(150);
		set_edge(5'd5);
		fill_table(1'b0, 5);
		idle_pct = 80;
		random_pixels(120);
		drain(); // sender holds off until all results are in
		set_edge(5'd17);
		pix_max = span_limit(4);
		idle_pct = 0;
		random_pixels(330);
		set_edge(5'd3);
		fill_table(1'b0, 3);
		random_pixels(150);
		set_edge(5'd1);
		send_item(pixel_item(16'hffff, 16'h0000, 16'h8000));
		drain();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_edges_and_idling();
		$display("covered %0d pixels and %0d table loads over edges 0 to 31 with idling",
			n_pixels, n_loads);
		if (errors == 0) begin
			$display("lut3d_tetrahedral_interp_top regression: pass");
		end else begin
			$display("lut3d_tetrahedral_interp_top regression: fail");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("lut3d_tetrahedral_interp_top regression: fail");
		$finish;
	end

endmodule
